// ===== src/ipc_pkg.sv =====
package ipc_pkg;

    localparam int FIELD_BITS = 64;
    localparam int CNT_BITS   = 64;
    localparam int ACC_BITS   = CNT_BITS + 8;
    localparam int PCT_BITS   = 7;
    localparam int SLOTS      = 8;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int DIV_STEPS  = PCT_BITS;
    localparam int STEP_BITS  = $clog2(DIV_STEPS);

    localparam logic [SLOT_BITS-1:0] SLOT_USER = SLOT_BITS'(0);
    localparam logic [SLOT_BITS-1:0] SLOT_IDLE = SLOT_BITS'(3);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);
    localparam logic [PCT_BITS-1:0]  PCT_FULL  = PCT_BITS'(100);

    // multiply by 100 as (x << 6) + (x << 5) + (x << 2)
    localparam int MUL_SHIFT_A = 6;
    localparam int MUL_SHIFT_B = 5;
    localparam int MUL_SHIFT_C = 2;

    localparam logic [STEP_BITS-1:0] MUL_STEP_B    = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] MUL_STEP_C    = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] MUL_STEP_HALF = STEP_BITS'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GUEST,
        S_DELTA,
        S_ACCUM,
        S_CMP,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [FIELD_BITS-1:0] user_ticks;
        logic [FIELD_BITS-1:0] nice_ticks;
        logic [FIELD_BITS-1:0] system_ticks;
        logic [FIELD_BITS-1:0] idle_ticks;
        logic [FIELD_BITS-1:0] iowait_ticks;
        logic [FIELD_BITS-1:0] irq_ticks;
        logic [FIELD_BITS-1:0] softirq_ticks;
        logic [FIELD_BITS-1:0] steal_ticks;
        logic [FIELD_BITS-1:0] guest_ticks;
    } t_sample;

    typedef struct packed {
        logic [PCT_BITS-1:0] idle_percent;
        logic                first_sample;
        logic                held_previous;
    } t_result;

    typedef struct packed {
        logic [ACC_BITS-1:0] a;
        logic [ACC_BITS-1:0] b;
        logic                sub;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_BITS-1:0] res;
        logic                no_borrow;
    } t_alu_rsp;

endpackage

// ===== src/ipc_in_if.sv =====
interface ipc_in_if
    import ipc_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ipc_out_if.sv =====
interface ipc_out_if
    import ipc_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ipc_alu.sv =====
module ipc_alu
    import ipc_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ACC_BITS:0] sum;

    // carry out of a - b is set when a >= b
    always_comb begin
        sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
              + (ACC_BITS + 1)'(i_req.sub);
        o_rsp.res       = sum[ACC_BITS-1:0];
        o_rsp.no_borrow = sum[ACC_BITS];
    end

endmodule

// ===== src/idle_percent_from_counter_deltas_unit.sv =====
// Idle percentage from nine cumulative time counters. Each accepted sample is
// compared with the stored one (user and guest folded together), and the block
// returns round(100 * idle / total) over the interval, saturated at 100, with
// first_sample set for the first sample after reset and held_previous set when
// the counters did not move (the last percentage is repeated and the stored
// snapshot is kept). All work runs on one shared 72-bit adder/subtractor under
// a small sequencer: one step for user plus guest, two per counter for the
// delta and running total, one compare, three adds for the times-100 product
// and its rounding term, and seven restoring division steps. A first sample
// skips all but the user-plus-guest step, and a held or saturated one skips
// the product and the division; the input is ready again the cycle after the
// result beat is taken.
module idle_percent_from_counter_deltas_unit
    import ipc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ipc_in_if.sink    i_sample,
    ipc_out_if.source o_result
);

    t_state               r_state, n_state;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [CNT_BITS-1:0]  r_now  [SLOTS];
    logic [CNT_BITS-1:0]  r_prev [SLOTS];
    logic [CNT_BITS-1:0]  r_guest;
    logic [CNT_BITS-1:0]  r_d, n_d;
    logic [CNT_BITS-1:0]  r_idle, n_idle;
    logic [CNT_BITS-1:0]  r_total, n_total;
    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [PCT_BITS-1:0]  r_quo, n_quo;
    logic [PCT_BITS-1:0]  r_prev_pct;
    logic                 r_have_prev;
    logic                 r_commit, n_commit;
    t_result              r_res, n_res;
    logic                 cap_en;
    logic                 user_wr;
    logic                 commit_en;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;

    ipc_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_result.valid = (r_state == S_OUT);
    assign o_result.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_step      <= '0;
            r_commit    <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_pct  <= PCT_FULL;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_step   <= n_step;
            r_commit <= n_commit;
            if (commit_en) begin
                r_have_prev <= 1'b1;
                r_prev_pct  <= r_res.idle_percent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_idle  <= n_idle;
        r_total <= n_total;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_res   <= n_res;
        if (cap_en) begin
            r_now[0] <= i_sample.data.user_ticks[CNT_BITS-1:0];
            r_now[1] <= i_sample.data.nice_ticks[CNT_BITS-1:0];
            r_now[2] <= i_sample.data.system_ticks[CNT_BITS-1:0];
            r_now[3] <= i_sample.data.idle_ticks[CNT_BITS-1:0];
            r_now[4] <= i_sample.data.iowait_ticks[CNT_BITS-1:0];
            r_now[5] <= i_sample.data.irq_ticks[CNT_BITS-1:0];
            r_now[6] <= i_sample.data.softirq_ticks[CNT_BITS-1:0];
            r_now[7] <= i_sample.data.steal_ticks[CNT_BITS-1:0];
            r_guest  <= i_sample.data.guest_ticks[CNT_BITS-1:0];
        end else if (user_wr) begin
            r_now[SLOT_USER] <= alu_rsp.res[CNT_BITS-1:0];
        end
        if (commit_en) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_prev[i] <= r_now[i];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_step    = r_step;
        n_d       = r_d;
        n_idle    = r_idle;
        n_total   = r_total;
        n_acc     = r_acc;
        n_quo     = r_quo;
        n_res     = r_res;
        n_commit  = r_commit;
        cap_en    = 1'b0;
        user_wr   = 1'b0;
        commit_en = 1'b0;
        alu_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    cap_en  = 1'b1;
                    n_state = S_GUEST;
                end
            end
            S_GUEST: begin
                alu_req.a = ACC_BITS'(r_now[SLOT_USER]);
                alu_req.b = ACC_BITS'(r_guest);
                user_wr   = 1'b1;
                n_slot    = '0;
                n_total   = '0;
                if (r_have_prev) begin
                    n_state = S_DELTA;
                end else begin
                    n_res    = '{idle_percent: PCT_FULL, first_sample: 1'b1,
                                 held_previous: 1'b0};
                    n_commit = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_DELTA: begin
                alu_req.a   = ACC_BITS'(r_now[r_slot]);
                alu_req.b   = ACC_BITS'(r_prev[r_slot]);
                alu_req.sub = 1'b1;
                n_d         = alu_rsp.res[CNT_BITS-1:0];
                if (r_slot == SLOT_IDLE) begin
                    n_idle = alu_rsp.res[CNT_BITS-1:0];
                end
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                alu_req.a = ACC_BITS'(r_total);
                alu_req.b = ACC_BITS'(r_d);
                n_total   = alu_rsp.res[CNT_BITS-1:0];
                if (r_slot == SLOT_LAST) begin
                    n_state = S_CMP;
                end else begin
                    n_slot  = r_slot + SLOT_BITS'(1);
                    n_state = S_DELTA;
                end
            end
            S_CMP: begin
                alu_req.a   = ACC_BITS'(r_idle);
                alu_req.b   = ACC_BITS'(r_total);
                alu_req.sub = 1'b1;
                if (r_total == '0) begin
                    n_res    = '{idle_percent: r_prev_pct, first_sample: 1'b0,
                                 held_previous: 1'b1};
                    n_commit = 1'b0;
                    n_state  = S_OUT;
                end else if (alu_rsp.no_borrow) begin
                    // idle at least total: saturate
                    n_res    = '{idle_percent: PCT_FULL, first_sample: 1'b0,
                                 held_previous: 1'b0};
                    n_commit = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_acc   = ACC_BITS'(r_idle) << MUL_SHIFT_A;
                    n_step  = MUL_STEP_B;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                alu_req.a = r_acc;
                unique case (r_step)
                    MUL_STEP_B: alu_req.b = ACC_BITS'(r_idle) << MUL_SHIFT_B;
                    MUL_STEP_C: alu_req.b = ACC_BITS'(r_idle) << MUL_SHIFT_C;
                    // rounding term: half of the total
                    default:    alu_req.b = ACC_BITS'(r_total >> 1);
                endcase
                n_acc = alu_rsp.res;
                if (r_step == MUL_STEP_HALF) begin
                    n_step  = STEP_BITS'(DIV_STEPS - 1);
                    n_quo   = '0;
                    n_state = S_DIV;
                end else begin
                    n_step = r_step + STEP_BITS'(1);
                end
            end
            S_DIV: begin
                // quotient is below 128, so seven trial subtractions cover it
                alu_req.a   = r_acc;
                alu_req.b   = ACC_BITS'(r_total) << r_step;
                alu_req.sub = 1'b1;
                if (alu_rsp.no_borrow) begin
                    n_acc         = alu_rsp.res;
                    n_quo[r_step] = 1'b1;
                end
                if (r_step == '0) begin
                    n_res    = '{idle_percent: n_quo, first_sample: 1'b0,
                                 held_previous: 1'b0};
                    n_commit = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            S_OUT: begin
                if (o_result.ready) begin
                    commit_en = r_commit;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
